FILE: hw/rtl/infix_to_postfix_converter_top_defines.svh
// assertion macros for the infix-to-postfix converter checker
// no dependencies; included by the checker file
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define I2P_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2p assertion failed");

// next-cycle implication, disabled during reset
`define I2P_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2p assertion failed");

`endif

FILE: hw/rtl/i2p_pkg.sv
// shared types, constants and functions of the infix-to-postfix converter
// no dependencies; imported by every rtl module
`timescale 1ns / 1ps

package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int SP_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int Q_DEPTH = 2;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  localparam logic [1:0] PREC_POW = 2'd3;
  localparam logic [1:0] PREC_MUL = 2'd2;
  localparam logic [1:0] PREC_ADD = 2'd1;
  localparam logic [1:0] PREC_NONE = 2'd0;

  typedef enum logic [2:0] {
    K_SKIP,
    K_LETTER,
    K_LPAREN,
    K_RPAREN,
    K_OPER
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
    logic [1:0] prec;
    logic       eoe;
  } cmd_t;

  function automatic kind_t classify(input logic [7:0] ch);
    kind_t k;
    case (ch) inside
      [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]:        k = K_LETTER;
      CH_LPAREN:                                   k = K_LPAREN;
      CH_RPAREN:                                   k = K_RPAREN;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: k = K_OPER;
      default:                                     k = K_SKIP;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] prec_of(input logic [7:0] ch);
    logic [1:0] p;
    case (ch) inside
      CH_CARET:          p = PREC_POW;
      CH_STAR, CH_SLASH: p = PREC_MUL;
      CH_PLUS, CH_MINUS: p = PREC_ADD;
      default:           p = PREC_NONE;
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/infix_to_postfix_converter_top.sv
// Shunting-yard infix-to-postfix converter, 32-entry operator stack.
// A letter passes the command queue, the command register and the output register
// before it shows on out_tvalid. The stack engine loads each character, then runs
// it, popping outranked operators in turn, and takes no new one until it is done;
// end of expression pops every stacked entry; an empty stack gives a bare end marker.
// Reset (rst_n low, synchronous) empties stack, queue and output; stack contents stay.
`timescale 1ns / 1ps

module infix_to_postfix_converter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic       in_tlast,   // end_of_expr
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] symbol
  output logic [1:0] out_tuser,  // [0] symbol_valid, [1] overflow
  output logic       out_tlast   // last
);
  import i2p_pkg::*;

  cmd_t wr_cmd, rd_cmd;
  logic q_wr, q_full, q_rd, q_valid;

  i2p_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wr_cmd  (wr_cmd)
  );

  i2p_cmd_q u_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_cmd   (wr_cmd),
    .full     (q_full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_cmd   (rd_cmd)
  );

  i2p_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (rd_cmd),
    .q_rd       (q_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hw/rtl/i2p_front.sv
// front end: takes input requests, classifies each character into a command
// depends on i2p_pkg; feeds i2p_cmd_q
`timescale 1ns / 1ps

module i2p_front (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] char_in
  input  logic          in_tlast,   // end_of_expr
  input  logic          q_full,
  output logic          q_wr,
  output i2p_pkg::cmd_t q_wr_cmd
);
  import i2p_pkg::*;

  assign in_tready = !q_full;
  assign q_wr      = in_tvalid && !q_full;

  always_comb begin
    q_wr_cmd.ch   = in_tdata;
    q_wr_cmd.kind = classify(in_tdata);
    q_wr_cmd.prec = prec_of(in_tdata);
    q_wr_cmd.eoe  = in_tlast;
  end

endmodule

FILE: hw/rtl/i2p_cmd_q.sv
// short command queue between the front end and the stack engine
// depends on i2p_pkg
`timescale 1ns / 1ps

module i2p_cmd_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  i2p_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd,
  output logic          rd_valid,
  output i2p_pkg::cmd_t rd_cmd
);
  import i2p_pkg::*;

  cmd_t            slot_r [Q_DEPTH];
  logic [QP_W-1:0] wp_r, wp_nxt;
  logic [QP_W-1:0] rp_r, rp_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign full     = (cnt_r == QC_W'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = slot_r[rp_r];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == QP_W'(Q_DEPTH - 1)) ? '0 : wp_r + QP_W'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == QP_W'(Q_DEPTH - 1)) ? '0 : rp_r + QP_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + QC_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_cmd;
    end
  end

endmodule

FILE: hw/rtl/i2p_back.sv
// stack engine: runs each command against the operator stack, one action per cycle
// while output is free, and drives the registered result channel. depends on i2p_pkg
`timescale 1ns / 1ps

module i2p_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  i2p_pkg::cmd_t q_cmd,
  output logic          q_rd,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,  // [7:0] symbol
  output logic [1:0]    out_tuser,  // [0] symbol_valid, [1] overflow
  output logic          out_tlast   // last
);
  import i2p_pkg::*;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r;
  logic [7:0]       stack_r [STACK_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;

  logic             ov_r;
  logic [7:0]       osym_r;
  logic             osv_r, olast_r, oovf_r;

  logic [CNT_W-1:0] top_dec;
  logic [7:0]       top_ch;
  logic [1:0]       top_prec;
  logic             nonempty, top_lp, outranks, slot_free, full;

  logic             emit, e_valid, e_last, push, pop, done, clr_ovf;
  logic [7:0]       e_sym;

  assign top_dec   = count_r - CNT_W'(1);
  assign top_ch    = stack_r[top_dec[SP_W-1:0]];
  assign top_prec  = prec_of(top_ch);
  assign nonempty  = (count_r != '0);
  assign top_lp    = (top_ch == CH_LPAREN);
  assign full      = (count_r == CNT_W'(STACK_DEPTH));
  assign slot_free = !ov_r || out_tready;
  // '^' is right-associative: equal precedence does not pop it
  assign outranks  = (top_prec > cmd_r.prec) ||
                     ((top_prec == cmd_r.prec) && (cmd_r.ch != CH_CARET));

  // actions of the current cycle
  always_comb begin
    q_rd    = 1'b0;
    emit    = 1'b0;
    e_sym   = top_ch;
    e_valid = 1'b1;
    e_last  = 1'b0;
    push    = 1'b0;
    pop     = 1'b0;
    done    = 1'b0;
    clr_ovf = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_rd = q_valid;
      end
      ST_EXEC: begin
        case (cmd_r.kind)
          K_LETTER: begin
            if (slot_free) begin
              emit  = 1'b1;
              e_sym = cmd_r.ch;
              done  = 1'b1;
            end
          end
          K_LPAREN: begin
            push = 1'b1;
            done = 1'b1;
          end
          K_RPAREN: begin
            if (nonempty && !top_lp) begin
              if (slot_free) begin
                emit = 1'b1;
                pop  = 1'b1;
              end
            end else begin
              // matching '(' is dropped; unmatched ')' does nothing more
              pop  = nonempty;
              done = 1'b1;
            end
          end
          K_OPER: begin
            if (nonempty && !top_lp && outranks) begin
              if (slot_free) begin
                emit = 1'b1;
                pop  = 1'b1;
              end
            end else begin
              push = 1'b1;
              done = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      ST_FLUSH: begin
        if (slot_free) begin
          emit = 1'b1;
          if (nonempty) begin
            pop    = 1'b1;
            e_last = (count_r == CNT_W'(1));
          end else begin
            // empty flush gives a bare end marker
            e_sym   = 8'h00;
            e_valid = 1'b0;
            e_last  = 1'b1;
          end
          clr_ovf = e_last;
        end
      end
      default: begin
        q_rd = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = ST_EXEC;
      ST_EXEC:  if (done) state_nxt = cmd_r.eoe ? ST_FLUSH : ST_IDLE;
      ST_FLUSH: if (emit && e_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (pop) begin
      count_nxt = top_dec;
    end else if (push) begin
      if (full) ovf_nxt = 1'b1;
      else      count_nxt = count_r + CNT_W'(1);
    end
    if (clr_ovf) begin
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (emit)            ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cmd_r <= q_cmd;
    end
    if (push && !full) begin
      stack_r[count_r[SP_W-1:0]] <= cmd_r.ch;
    end
    if (emit) begin
      osym_r  <= e_sym;
      osv_r   <= e_valid;
      olast_r <= e_last;
      oovf_r  <= ovf_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = osym_r;
  assign out_tuser  = {oovf_r, osv_r};
  assign out_tlast  = olast_r;

endmodule

FILE: hw/rtl/i2p_checker.sv
// port-level checks of the infix-to-postfix converter, bound to the top level
// depends on i2p_pkg and infix_to_postfix_converter_top_defines.svh
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_top_defines.svh"

module i2p_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);
  import i2p_pkg::*;

  logic        out_marker;
  logic        out_stall;
  logic        sym_legal;
  logic [10:0] out_bus;

  assign out_marker = out_tvalid && !out_tuser[0];
  assign out_stall  = out_tvalid && !out_tready;
  assign out_bus    = {out_tlast, out_tuser, out_tdata};

  // only letters, operators and leftover '(' ever reach the output
  assign sym_legal = out_tdata inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z], CH_LPAREN,
                                       CH_STAR, CH_PLUS, CH_MINUS, CH_SLASH, CH_CARET};

  // a result without a character is only ever the end marker
  `I2P_ASSERT_NOW(a_marker_is_last, clk, rst_n, out_marker, out_tlast)

  `I2P_ASSERT_NOW(a_marker_is_zero, clk, rst_n, out_marker, out_tdata == 8'h00)

  `I2P_ASSERT_NOW(a_symbol_legal, clk, rst_n, out_tvalid && out_tuser[0], sym_legal)

  `I2P_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_bus))

endmodule

bind infix_to_postfix_converter_top i2p_checker u_i2p_checker (.*);
